// ----- hdl/clutter_background_subtract_core_macros.svh -----
// Assertion macros for the clutter background subtract core.
// Included by the top level; no other dependencies.
`ifndef CLUTTER_BACKGROUND_SUBTRACT_CORE_MACROS_SVH
`define CLUTTER_BACKGROUND_SUBTRACT_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CBS_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define CBS_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/cbs_pkg.sv -----
// Shared constants, types and state encoding for the clutter background subtract core.
// No dependencies.
package cbs_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int OUT_W      = SAMPLE_W + 1;
    localparam int MAX_SC     = 256;
    localparam int MAX_WIN    = 64;
    localparam int SC_IDX_W   = $clog2(MAX_SC);
    localparam int NSC_W      = 9;
    localparam int WIN_W      = 7;
    localparam int SLOT_W     = $clog2(MAX_WIN);
    localparam int FRAMES_W   = $clog2(MAX_WIN) + 1;
    // sum of up to MAX_WIN samples, magnitude up to MAX_WIN * 2^(SAMPLE_W-1)
    localparam int SUM_W      = SAMPLE_W + $clog2(MAX_WIN);
    localparam int RING_AW    = SLOT_W + SC_IDX_W;
    localparam int DIV_STEPS  = SUM_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
    localparam int REM_W      = FRAMES_W + 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = NSC_W;

    localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(8);
    localparam logic [NSC_W-1:0] SUBC_RESET   = NSC_W'(64);

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW      = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SUBCARRIERS = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_FINISH
    } cbs_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_sts_t;

endpackage

// ----- hdl/cbs_if.sv -----
// Valid/ready channel interfaces: sample input, result output, register write.
// Depends on cbs_pkg.
interface cbs_in_if import cbs_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_re;
    logic signed [SAMPLE_W-1:0] sample_im;

    modport source (output valid, output sample_re, output sample_im, input ready);
    modport sink   (input valid, input sample_re, input sample_im, output ready);
endinterface

interface cbs_out_if import cbs_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] out_re;
    logic signed [OUT_W-1:0] out_im;
    logic                    frame_end;

    modport source (output valid, output out_re, output out_im, output frame_end,
                    input ready);
    modport sink   (input valid, input out_re, input out_im, input frame_end,
                    output ready);
endinterface

interface cbs_cfg_if import cbs_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hdl/clutter_background_subtract_core.sv -----
// Channel   | Dir | Payload                      | Transfer
// samples   | in  | sample_re, sample_im         | valid & ready
// results   | out | out_re, out_im, frame_end    | valid & ready
// cfg       | in  | index (0 window, 1 subcarr.) | valid & ready, always ready
// Between one sample transfer and the next possible transfer the core passes the accept
// cycle (sum and ring memories read at its edge), ST_LOAD to start the divider, ST_DIV in
// the shared bit-serial divider (its quotient steps and the done cycle), and ST_FINISH to
// write back and load the output register.
// Reset or a write to index 0 or 1 clears sums (valid bits), frame count, slot, index.
// A result waiting on results.ready stalls the write-back; the next sample is
// accepted as soon as the previous result sits in the output register.
// Depends on cbs_pkg, cbs_if, cbs_div and the macros header.
`include "clutter_background_subtract_core_macros.svh"

module clutter_background_subtract_core import cbs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    cbs_in_if.sink    samples,
    cbs_out_if.source results,
    cbs_cfg_if.sink   cfg
);

    cbs_state_t state_reg;
    cbs_state_t state_next;

    logic [WIN_W-1:0]    window_reg;
    logic [NSC_W-1:0]    subc_reg;
    logic [FRAMES_W-1:0] frames_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [SC_IDX_W-1:0] idx_reg;
    logic [MAX_SC-1:0]   sum_valid_reg;

    logic [WIN_W-1:0] eff_w;
    logic [NSC_W-1:0] eff_n;

    logic signed [SAMPLE_W-1:0] xr_reg;
    logic signed [SAMPLE_W-1:0] xi_reg;
    logic                       hit_reg;
    logic [2*SUM_W-1:0]         sum_rd_reg;
    logic [2*SAMPLE_W-1:0]      ring_rd_reg;

    logic [2*SUM_W-1:0]    sum_mem  [MAX_SC];
    logic [2*SAMPLE_W-1:0] ring_mem [MAX_SC * MAX_WIN];

    logic signed [OUT_W-1:0] out_re_reg;
    logic signed [OUT_W-1:0] out_im_reg;
    logic                    frame_end_reg;
    logic                    out_valid_reg;

    logic in_go;
    logic cfg_go;
    logic finish_go;
    logic div_start;
    logic in_ready;
    logic last;
    logic full;

    logic [RING_AW-1:0]      ring_addr;
    logic [WIN_W-1:0]        slot_inc;
    logic signed [SUM_W-1:0] sum_re;
    logic signed [SUM_W-1:0] sum_im;
    logic signed [SUM_W-1:0] old_re;
    logic signed [SUM_W-1:0] old_im;
    logic signed [SUM_W-1:0] new_re;
    logic signed [SUM_W-1:0] new_im;
    logic signed [SUM_W-1:0] quo_re;
    logic signed [SUM_W-1:0] quo_im;
    logic signed [OUT_W-1:0] mean_re;
    logic signed [OUT_W-1:0] mean_im;
    div_sts_t                div_sts;

    // effective register values
    always_comb
    begin
        if (window_reg < WIN_W'(2))
            eff_w = WIN_W'(2);
        else if (window_reg > WIN_W'(MAX_WIN))
            eff_w = WIN_W'(MAX_WIN);
        else
            eff_w = window_reg;

        if (subc_reg == '0)
            eff_n = NSC_W'(1);
        else if (subc_reg > NSC_W'(MAX_SC))
            eff_n = NSC_W'(MAX_SC);
        else
            eff_n = subc_reg;
    end

    assign in_go     = samples.valid && in_ready;
    assign cfg_go    = cfg.valid;
    assign ring_addr = {slot_reg, idx_reg};
    assign last      = ({1'b0, idx_reg} + NSC_W'(1)) >= eff_n;
    assign full      = frames_reg == eff_w;
    assign slot_inc  = {1'b0, slot_reg} + WIN_W'(1);

    // sums of a subcarrier never written since the last clear read as zero
    assign sum_re = hit_reg ? sum_rd_reg[2*SUM_W-1:SUM_W] : '0;
    assign sum_im = hit_reg ? sum_rd_reg[SUM_W-1:0]       : '0;
    assign old_re = full ? SUM_W'(signed'(ring_rd_reg[2*SAMPLE_W-1:SAMPLE_W])) : '0;
    assign old_im = full ? SUM_W'(signed'(ring_rd_reg[SAMPLE_W-1:0]))          : '0;
    assign new_re = sum_re - old_re + SUM_W'(xr_reg);
    assign new_im = sum_im - old_im + SUM_W'(xi_reg);

    assign mean_re = (frames_reg == '0) ? '0 : quo_re[OUT_W-1:0];
    assign mean_im = (frames_reg == '0) ? '0 : quo_im[OUT_W-1:0];

    cbs_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .divisor (frames_reg),
        .num_re  (sum_re),
        .num_im  (sum_im),
        .quo_re  (quo_re),
        .quo_im  (quo_im),
        .sts     (div_sts)
    );

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        div_start  = 1'b0;
        finish_go  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (samples.valid)
                    state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_sts.done)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || results.ready)
                begin
                    finish_go  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // registers, counters, sum valid bits, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg    <= WINDOW_RESET;
            subc_reg      <= SUBC_RESET;
            frames_reg    <= '0;
            slot_reg      <= '0;
            idx_reg       <= '0;
            sum_valid_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_go)
            begin
                unique case (cfg.index)
                    REG_WINDOW:      window_reg <= cfg.data[WIN_W-1:0];
                    REG_SUBCARRIERS: subc_reg   <= cfg.data;
                    default:         ;
                endcase
                if (cfg.index == REG_WINDOW || cfg.index == REG_SUBCARRIERS)
                begin
                    frames_reg    <= '0;
                    slot_reg      <= '0;
                    idx_reg       <= '0;
                    sum_valid_reg <= '0;
                end
            end
            else if (finish_go)
            begin
                sum_valid_reg[idx_reg] <= 1'b1;
                if (last)
                begin
                    idx_reg <= '0;
                    if (frames_reg < eff_w)
                        frames_reg <= frames_reg + FRAMES_W'(1);
                    slot_reg <= (slot_inc >= eff_w) ? '0 : slot_inc[SLOT_W-1:0];
                end
                else
                begin
                    idx_reg <= idx_reg + SC_IDX_W'(1);
                end
            end

            if (finish_go)
                out_valid_reg <= 1'b1;
            else if (results.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // memories and item payload
    always_ff @(posedge clk)
    begin
        if (in_go)
        begin
            xr_reg      <= samples.sample_re;
            xi_reg      <= samples.sample_im;
            hit_reg     <= sum_valid_reg[idx_reg];
            sum_rd_reg  <= sum_mem[idx_reg];
            ring_rd_reg <= ring_mem[ring_addr];
        end
        if (finish_go)
        begin
            sum_mem[idx_reg]    <= {new_re, new_im};
            ring_mem[ring_addr] <= {xr_reg, xi_reg};
            out_re_reg          <= OUT_W'(xr_reg) - mean_re;
            out_im_reg          <= OUT_W'(xi_reg) - mean_im;
            frame_end_reg       <= last;
        end
    end

    assign samples.ready     = in_ready;
    assign cfg.ready         = 1'b1;
    assign results.valid     = out_valid_reg;
    assign results.out_re    = out_re_reg;
    assign results.out_im    = out_im_reg;
    assign results.frame_end = frame_end_reg;

    `CBS_ASSERT_IMP(a_frames_le_window, clk, rst_n, 1'b1, frames_reg <= eff_w,
        "frame count above window")
    `CBS_ASSERT_IMP(a_slot_lt_window, clk, rst_n, 1'b1, {1'b0, slot_reg} < eff_w,
        "ring slot out of window")
    `CBS_ASSERT_IMP(a_accept_div_idle, clk, rst_n, samples.valid && samples.ready,
        !div_sts.busy, "sample taken while divider busy")
    `CBS_ASSERT_NEXT(a_one_item_at_a_time, clk, rst_n, samples.valid && samples.ready,
        !samples.ready, "sample taken on consecutive cycles")

endmodule

// ----- hdl/cbs_div.sv -----
// Two-lane restoring divider, one quotient bit per cycle, signed dividend over
// an unsigned divisor with truncation toward zero. Depends on cbs_pkg.
module cbs_div import cbs_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [FRAMES_W-1:0]     divisor,
    input  logic signed [SUM_W-1:0] num_re,
    input  logic signed [SUM_W-1:0] num_im,
    output logic signed [SUM_W-1:0] quo_re,
    output logic signed [SUM_W-1:0] quo_im,
    output div_sts_t                sts
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [FRAMES_W-1:0]  dsr_reg;
    logic [SUM_W-1:0]     dvd_reg  [2];
    logic [REM_W-1:0]     rem_reg  [2];
    logic                 neg_reg  [2];
    logic [SUM_W-1:0]     dvd_next [2];
    logic [REM_W-1:0]     rem_next [2];
    logic signed [SUM_W-1:0] num [2];

    assign num[0] = num_re;
    assign num[1] = num_im;

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            logic [REM_W-1:0] trial;
            trial = {rem_reg[l][REM_W-2:0], dvd_reg[l][SUM_W-1]};
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next[l] = trial - {1'b0, dsr_reg};
                dvd_next[l] = {dvd_reg[l][SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[l] = trial;
                dvd_next[l] = {dvd_reg[l][SUM_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath: dividend register shifts out, quotient bits shift in
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dsr_reg <= divisor;
            for (int l = 0; l < 2; l++)
            begin
                neg_reg[l] <= num[l][SUM_W-1];
                dvd_reg[l] <= num[l][SUM_W-1] ? SUM_W'(-num[l]) : SUM_W'(num[l]);
                rem_reg[l] <= '0;
            end
        end
        else if (busy_reg)
        begin
            for (int l = 0; l < 2; l++)
            begin
                dvd_reg[l] <= dvd_next[l];
                rem_reg[l] <= rem_next[l];
            end
        end
    end

    assign quo_re   = neg_reg[0] ? SUM_W'(-dvd_reg[0]) : dvd_reg[0];
    assign quo_im   = neg_reg[1] ? SUM_W'(-dvd_reg[1]) : dvd_reg[1];
    assign sts.busy = busy_reg;
    assign sts.done = done_reg;

endmodule
